>>> rtl/core/llra_pkg.sv
// Shared package of the loop length rational approximation unit.
// Holds constants, datapath command codes, controller states and the
// command/status structs. Depends on nothing.
`default_nettype none
package llra_pkg;

    localparam int TERMS_DEFAULT = 8;
    localparam int CFG_ADDR_W    = 3;
    localparam int DIVD_W        = 65;
    localparam int DIVS_W        = 33;

    localparam logic [15:0] MAX_LEN_RESET = 16'd8000;
    localparam logic        REG_MAX_LOOP  = 1'b0;

    localparam logic [63:0] RATIO_MAX     = 64'h7FFF_FFFF_0000_0000;
    localparam logic [63:0] BIG_X         = 64'h000F_4240_0000_0000;
    localparam logic [63:0] NEAR_ZERO_RAW = 64'd4295;
    localparam logic signed [32:0] SAT_POS = 33'sh0_8000_0000;
    localparam logic signed [32:0] SAT_NEG = -33'sh0_8000_0000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_TRIVIAL,
        OP_DIV_RATIO,
        OP_SET_X,
        OP_TERM,
        OP_MUL_REC,
        OP_ACC_REC,
        OP_NORM,
        OP_MUL_A,
        OP_MUL_B,
        OP_DIFF,
        OP_CONV,
        OP_SET_BIG,
        OP_DIV_RECIP,
        OP_SET_RECIP,
        OP_MUL_MF,
        OP_DIV_C,
        OP_SET_C,
        OP_DIV_L,
        OP_SET_L,
        OP_MUL_FL,
        OP_FLAG,
        OP_PUSH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK_IN,
        S_DIV_RATIO,
        S_TERM,
        S_REC,
        S_ACC,
        S_SPLIT,
        S_MUL_B,
        S_DIFF,
        S_DECIDE,
        S_DIV_RECIP,
        S_DIV_C,
        S_WAIT_C,
        S_DIV_L,
        S_WAIT_L,
        S_MUL_FL,
        S_FLAG,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_in;
        logic div_busy;
        logic j_zero;
        logic num_le_m;
        logic close;
        logic last_term;
        logic near_zero;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/llra_div.sv
// Restoring divider, one quotient bit per cycle.
// 65-bit dividend, 33-bit divisor; uses llra_pkg for widths.
`default_nettype none
module llra_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [llra_pkg::DIVD_W-1:0] dividend,
    input  wire logic [llra_pkg::DIVS_W-1:0] divisor,
    output logic                            busy,
    output logic [llra_pkg::DIVD_W-1:0]     quotient,
    output logic [llra_pkg::DIVS_W-1:0]     remainder
);
    import llra_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        ge    = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
            cnt_reg  <= CNT_W'(DIVD_W);
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

>>> rtl/core/llra_datapath.sv
// Datapath: ratio, term store, convergent recurrence, deviation tests,
// fallback and output register. Uses llra_pkg and llra_div.
`default_nettype none
module llra_datapath #(
    parameter int TERMS = llra_pkg::TERMS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire llra_pkg::dp_cmd_t    cmd,
    output llra_pkg::dp_status_t      status,
    input  wire logic [31:0]          s_tone_freq,
    input  wire logic [31:0]          s_rate_hz,
    input  wire logic [15:0]          max_len,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic [16:0]               m_loop_length,
    output logic [15:0]               m_cycle_count,
    output logic                      m_large_error
);
    import llra_pkg::*;

    localparam int IW = (TERMS > 1) ? $clog2(TERMS) : 1;

    logic [31:0]        f_reg;
    logic [31:0]        r_reg;
    logic [15:0]        m_reg;
    logic signed [63:0] x_reg;
    logic signed [32:0] term_reg [TERMS];
    logic [IW-1:0]      i_reg;
    logic [IW-1:0]      j_reg;
    logic signed [32:0] num_reg;
    logic signed [32:0] den_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        a_reg;
    logic [63:0]        b_reg;
    logic [63:0]        d_reg;
    logic [47:0]        c_reg;
    logic [16:0]        l_reg;
    logic [16:0]        len_reg;
    logic [15:0]        cyc_reg;
    logic               flag_reg;
    logic               m_valid_reg;
    logic [16:0]        out_len_reg;
    logic [15:0]        out_cyc_reg;
    logic               out_flag_reg;

    logic [63:0]        x_mag;
    logic [64:0]        rnd_sum;
    logic [32:0]        rnd_mag;
    logic signed [32:0] a_term;
    logic [IW-1:0]      jm1;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [32:0]        num_mag;
    logic [32:0]        den_mag;
    logic signed [63:0] rec_sum;
    logic signed [32:0] rec_sat;
    logic [63:0]        d_close;
    logic [27:0]        d28;
    logic [47:0]        lhs1;
    logic [63:0]        lhs2;
    logic [65:0]        rhs2;
    logic [63:0]        d_fb;
    logic               flag_fb;
    logic [63:0]        ratio_sat;
    logic [63:0]        recip_x;
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic               div_busy;
    logic [DIVD_W-1:0]  div_q;
    logic [DIVS_W-1:0]  div_rem;
    logic               out_free;

    llra_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    always_comb begin
        x_mag   = x_reg[63] ? 64'(-x_reg) : 64'(x_reg);
        rnd_sum = {1'b0, x_mag} + 65'h0_8000_0000;
        rnd_mag = rnd_sum[64:32];
        a_term  = x_reg[63] ? -$signed(rnd_mag) : $signed(rnd_mag);
        jm1     = j_reg - 1'b1;
        num_mag = num_reg[32] ? 33'(-num_reg) : 33'(num_reg);
        den_mag = den_reg[32] ? 33'(-den_reg) : 33'(den_reg);

        // shared multiplier operand select
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_REC: begin
                mul_a = term_reg[jm1];
                mul_b = num_reg;
            end
            OP_MUL_A: begin
                mul_a = $signed({1'b0, r_reg});
                mul_b = $signed(den_mag);
            end
            OP_MUL_B: begin
                mul_a = $signed({1'b0, f_reg});
                mul_b = num_reg;
            end
            OP_MUL_MF: begin
                mul_a = $signed({17'b0, m_reg});
                mul_b = $signed({1'b0, f_reg});
            end
            OP_MUL_FL: begin
                mul_a = $signed({1'b0, f_reg});
                mul_b = $signed({16'b0, l_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        rec_sum = prod_reg + {{31{den_reg[32]}}, den_reg};
        if (rec_sum > 64'sh8000_0000) begin
            rec_sat = SAT_POS;
        end else if (rec_sum < -64'sh8000_0000) begin
            rec_sat = SAT_NEG;
        end else begin
            rec_sat = rec_sum[32:0];
        end

        if (den_reg[32]) begin
            d_close = a_reg + b_reg;
        end else begin
            d_close = (a_reg > b_reg) ? a_reg - b_reg : b_reg - a_reg;
        end

        d28  = d_reg[27:0];
        lhs1 = 48'(d28) * 48'd10;
        lhs2 = 64'(d28) * 64'd10000;
        rhs2 = {2'b0, b_reg} + {1'b0, b_reg, 1'b0};

        d_fb    = (a_reg > b_reg) ? a_reg - b_reg : b_reg - a_reg;
        flag_fb = (c_reg != '0) &&
                  ((l_reg == '0) || (d_fb > {35'b0, l_reg, 12'b0}));

        ratio_sat = (div_q > {1'b0, RATIO_MAX}) ? RATIO_MAX : div_q[63:0];
        recip_x   = x_reg[63] ? -div_q[63:0] : div_q[63:0];

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (cmd.op)
            OP_DIV_RATIO: begin
                div_start    = 1'b1;
                div_dividend = {1'b0, r_reg, 32'b0};
                div_divisor  = {1'b0, f_reg};
            end
            OP_DIV_RECIP: begin
                div_start    = 1'b1;
                div_dividend = {1'b1, 64'b0};
                div_divisor  = x_mag[32:0];
            end
            OP_DIV_C: begin
                div_start    = 1'b1;
                div_dividend = {17'b0, a_reg[47:0]};
                div_divisor  = {1'b0, r_reg};
            end
            OP_DIV_L: begin
                div_start    = 1'b1;
                div_dividend = {a_reg, 1'b0} + {33'b0, f_reg};
                div_divisor  = {f_reg, 1'b0};
            end
            default: begin
                div_start    = 1'b0;
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase

        out_free = !m_valid_reg || m_ready;

        status.zero_in   = (f_reg == '0) || (r_reg == '0);
        status.div_busy  = div_busy;
        status.j_zero    = (j_reg == '0);
        status.num_le_m  = !num_reg[32] && (num_reg[31:0] <= {16'b0, m_reg});
        status.close     = !num_reg[32] && (num_reg != '0) &&
                           (d_reg[63:28] == '0) &&
                           (lhs1 < {3'b0, num_reg, 12'b0}) &&
                           ({2'b0, lhs2} < rhs2);
        status.last_term = (i_reg == IW'(TERMS - 1));
        status.near_zero = x_mag < NEAR_ZERO_RAW;
        status.out_free  = out_free;
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                f_reg <= s_tone_freq;
                r_reg <= s_rate_hz;
                m_reg <= max_len;
            end
            OP_TRIVIAL: begin
                len_reg  <= 17'd1;
                cyc_reg  <= 16'd1;
                flag_reg <= 1'b0;
            end
            OP_SET_X: begin
                x_reg <= $signed(ratio_sat);
                i_reg <= '0;
            end
            OP_TERM: begin
                term_reg[i_reg] <= a_term;
                x_reg   <= x_reg - $signed({a_term[31:0], 32'b0});
                num_reg <= a_term;
                den_reg <= 33'sd1;
                j_reg   <= i_reg;
            end
            OP_MUL_REC: begin
                prod_reg <= mul_p[63:0];
                j_reg    <= jm1;
            end
            OP_ACC_REC: begin
                num_reg <= rec_sat;
                den_reg <= num_reg;
            end
            OP_NORM: begin
                if (num_reg[32]) begin
                    num_reg <= -num_reg;
                    den_reg <= -den_reg;
                end
            end
            OP_MUL_A: a_reg <= mul_p[63:0];
            OP_MUL_B: b_reg <= mul_p[63:0];
            OP_DIFF:  d_reg <= d_close;
            OP_CONV: begin
                if (num_mag == '0) begin
                    len_reg <= 17'd1;
                end else if (num_mag > 33'd65536) begin
                    len_reg <= 17'h1_0000;
                end else begin
                    len_reg <= num_mag[16:0];
                end
                if (den_mag == '0) begin
                    cyc_reg <= 16'd1;
                end else if (den_mag > 33'd65535) begin
                    cyc_reg <= 16'hFFFF;
                end else begin
                    cyc_reg <= den_mag[15:0];
                end
                flag_reg <= 1'b0;
            end
            OP_SET_BIG: begin
                x_reg <= $signed(BIG_X);
                i_reg <= i_reg + 1'b1;
            end
            OP_SET_RECIP: begin
                x_reg <= $signed(recip_x);
                i_reg <= i_reg + 1'b1;
            end
            OP_MUL_MF: a_reg <= mul_p[63:0];
            OP_SET_C: begin
                c_reg <= div_q[47:0];
                // c*r is m*f less the remainder
                a_reg <= a_reg - {31'b0, div_rem};
            end
            OP_SET_L:  l_reg <= div_q[16:0];
            OP_MUL_FL: b_reg <= mul_p[63:0];
            OP_FLAG: begin
                len_reg <= (l_reg == '0) ? 17'd1 : l_reg;
                if (c_reg == '0) begin
                    cyc_reg <= 16'd1;
                end else if (c_reg > 48'd65535) begin
                    cyc_reg <= 16'hFFFF;
                end else begin
                    cyc_reg <= c_reg[15:0];
                end
                flag_reg <= flag_fb;
            end
            OP_PUSH: begin
                out_len_reg  <= len_reg;
                out_cyc_reg  <= cyc_reg;
                out_flag_reg <= flag_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_PUSH) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_loop_length = out_len_reg;
    assign m_cycle_count = out_cyc_reg;
    assign m_large_error = out_flag_reg;

endmodule
`default_nettype wire

>>> rtl/core/llra_ctrl.sv
// Controller state machine: sequences the datapath one command a cycle when
// not waiting on divider or output. Uses llra_pkg for states, commands, status.
`default_nettype none
module llra_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output llra_pkg::dp_cmd_t         cmd,
    input  wire llra_pkg::dp_status_t status
);
    import llra_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK_IN;
                end
            end
            S_CHECK_IN: begin
                if (status.zero_in) begin
                    cmd.op     = OP_TRIVIAL;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_DIV_RATIO;
                    state_next = S_DIV_RATIO;
                end
            end
            S_DIV_RATIO: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_SET_X;
                    state_next = S_TERM;
                end
            end
            S_TERM: begin
                cmd.op     = OP_TERM;
                state_next = S_REC;
            end
            S_REC: begin
                if (status.j_zero) begin
                    cmd.op     = OP_NORM;
                    state_next = S_SPLIT;
                end else begin
                    cmd.op     = OP_MUL_REC;
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.op     = OP_ACC_REC;
                state_next = S_REC;
            end
            S_SPLIT: begin
                // length over the limit: take the fallback
                if (!status.num_le_m) begin
                    cmd.op     = OP_MUL_MF;
                    state_next = S_DIV_C;
                end else begin
                    cmd.op     = OP_MUL_A;
                    state_next = S_MUL_B;
                end
            end
            S_MUL_B: begin
                cmd.op     = OP_MUL_B;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (status.close || status.last_term) begin
                    cmd.op     = OP_CONV;
                    state_next = S_OUT;
                end else if (status.near_zero) begin
                    cmd.op     = OP_SET_BIG;
                    state_next = S_TERM;
                end else begin
                    cmd.op     = OP_DIV_RECIP;
                    state_next = S_DIV_RECIP;
                end
            end
            S_DIV_RECIP: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_SET_RECIP;
                    state_next = S_TERM;
                end
            end
            S_DIV_C: begin
                cmd.op     = OP_DIV_C;
                state_next = S_WAIT_C;
            end
            S_WAIT_C: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_SET_C;
                    state_next = S_DIV_L;
                end
            end
            S_DIV_L: begin
                cmd.op     = OP_DIV_L;
                state_next = S_WAIT_L;
            end
            S_WAIT_L: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_SET_L;
                    state_next = S_MUL_FL;
                end
            end
            S_MUL_FL: begin
                cmd.op     = OP_MUL_FL;
                state_next = S_FLAG;
            end
            S_FLAG: begin
                cmd.op     = OP_FLAG;
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.op     = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/loop_length_rational_approx_unit.sv
// Loop length rational approximation unit, top level.
// A zero input goes straight to the push; otherwise the ratio is divided, then
// each term runs the recurrence and deviation tests, with a reciprocal divide
// before the next term, and the result is pushed; the fallback replaces a term's
// tests with two divides on the shared divider. One request at a time; the next
// is taken while a result waits in the output register. Reset: max_loop_length is 8000.
`default_nettype none
module loop_length_rational_approx_unit #(
    parameter int TERMS = llra_pkg::TERMS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [llra_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [31:0]                   s_tone_freq,
    input  wire logic [31:0]                   s_rate_hz,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [16:0]                        m_loop_length,
    output logic [15:0]                        m_cycle_count,
    output logic                               m_large_error
);
    import llra_pkg::*;

    logic [15:0] max_len_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_LOOP)) begin
            max_len_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LOOP) ? {16'b0, max_len_reg} : 32'b0;

    llra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    llra_datapath #(
        .TERMS (TERMS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_tone_freq   (s_tone_freq),
        .s_rate_hz     (s_rate_hz),
        .max_len       (max_len_reg),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_loop_length (m_loop_length),
        .m_cycle_count (m_cycle_count),
        .m_large_error (m_large_error)
    );

endmodule
`default_nettype wire
